// ===== src/bsp_pkg.sv =====
package bsp_pkg;

    localparam int ByteW   = 8;
    localparam int SymW    = 5;
    localparam int ResW    = 4;
    localparam int CntW    = 3;
    localparam int AccW    = ResW + ByteW;
    localparam int MaxSyms = 3;
    localparam int IdxW    = 2;

    localparam logic [CntW-1:0] ResMax  = 3'd4;
    localparam logic [SymW-1:0] SymMask = 5'h1f;

    typedef logic [SymW-1:0] sym_t;

endpackage

// ===== src/byte_to_5bit_symbol_splitter.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------
// byte in  | byte_valid, byte_ready | data_byte[7:0], last_byte
// symbol   | sym_valid, sym_ready   | symbol[4:0], last_symbol
//
// A byte is split into its one to three symbols in the cycle it is accepted.
// The symbols are held in a group register and move to the output register
// one per cycle while the symbol side is not stalled.
// A new byte is taken in the cycle the last symbol of the group moves out.
// Reset clears the leftover bits and the valid flags of the group and the output register.
// A stall on the symbol side holds the output word and then the group.
module byte_to_5bit_symbol_splitter
    import bsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  logic [ByteW-1:0] data_byte,
    input  logic             last_byte,
    output logic             sym_valid,
    input  logic             sym_ready,
    output logic [SymW-1:0]  symbol,
    output logic             last_symbol
);

    logic [ResW-1:0] residual_bits_reg;
    logic [ResW-1:0] residual_bits_next;
    logic [CntW-1:0] residual_count_reg;
    logic [CntW-1:0] residual_count_next;

    sym_t            grp_sym_reg [MaxSyms];
    sym_t            grp_sym_next [MaxSyms];
    logic [IdxW-1:0] grp_cnt_reg;
    logic [IdxW-1:0] grp_cnt_next;
    logic [IdxW-1:0] grp_idx_reg;
    logic            grp_last_reg;
    logic            grp_valid_reg;

    logic            sym_valid_reg;
    sym_t            symbol_reg;
    logic            last_symbol_reg;

    logic            accept;
    logic            load;
    logic            take_last;

    logic [CntW-1:0] cnt_sat;
    logic [ResW-1:0] res_mask;
    logic [AccW-1:0] acc;
    logic [3:0]      n_bits;
    logic            two_syms;
    logic [2:0]      rem;
    logic [ResW-1:0] rem_mask;
    logic [ResW-1:0] rem_bits;
    sym_t            sym0;
    sym_t            sym1;
    sym_t            flush_sym;

    always_comb
    begin
        cnt_sat  = (residual_count_reg > ResMax) ? ResMax : residual_count_reg;
        res_mask = ResW'((5'd1 << cnt_sat) - 5'd1);
        acc      = {residual_bits_reg & res_mask, data_byte};
        n_bits   = 4'(cnt_sat) + 4'd8;
        two_syms = (n_bits >= 4'd10);
        sym0     = SymMask & SymW'(acc >> (n_bits - 4'd5));
        sym1     = SymMask & SymW'(acc >> (n_bits - 4'd10));
        rem      = two_syms ? 3'(n_bits - 4'd10) : 3'(n_bits - 4'd5);
        rem_mask = ResW'((5'd1 << rem) - 5'd1);
        rem_bits = acc[ResW-1:0] & rem_mask;
        flush_sym = SymMask & SymW'({4'd0, rem_bits} << (3'd5 - rem));

        grp_sym_next[0] = sym0;
        grp_sym_next[1] = two_syms ? sym1 : flush_sym;
        grp_sym_next[2] = flush_sym;
        grp_cnt_next    = two_syms ? 2'd2 : 2'd1;
        if (last_byte && (rem != 3'd0))
        begin
            grp_cnt_next = grp_cnt_next + 2'd1;
        end

        if (last_byte)
        begin
            residual_bits_next  = '0;
            residual_count_next = '0;
        end
        else
        begin
            residual_bits_next  = rem_bits;
            residual_count_next = rem;
        end
    end

    assign load       = grp_valid_reg && (!sym_valid_reg || sym_ready);
    assign take_last  = load && (grp_idx_reg == (grp_cnt_reg - 2'd1));
    assign byte_ready = !grp_valid_reg || take_last;
    assign accept     = byte_valid && byte_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residual_bits_reg  <= '0;
            residual_count_reg <= '0;
            grp_valid_reg      <= 1'b0;
            grp_idx_reg        <= '0;
            sym_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                residual_bits_reg  <= residual_bits_next;
                residual_count_reg <= residual_count_next;
                grp_valid_reg      <= 1'b1;
                grp_idx_reg        <= '0;
            end
            else if (take_last)
            begin
                grp_valid_reg <= 1'b0;
            end
            else if (load)
            begin
                grp_idx_reg <= grp_idx_reg + 2'd1;
            end

            if (load)
            begin
                sym_valid_reg <= 1'b1;
            end
            else if (sym_ready)
            begin
                sym_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grp_sym_reg  <= grp_sym_next;
            grp_cnt_reg  <= grp_cnt_next;
            grp_last_reg <= last_byte;
        end
        if (load)
        begin
            symbol_reg      <= grp_sym_reg[grp_idx_reg];
            last_symbol_reg <= grp_last_reg && take_last;
        end
    end

    assign sym_valid   = sym_valid_reg;
    assign symbol      = symbol_reg;
    assign last_symbol = last_symbol_reg;

endmodule

// ===== src/bsp_checker.sv =====
module bsp_checker
    import bsp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             byte_valid,
    input logic             byte_ready,
    input logic             last_byte,
    input logic             sym_valid,
    input logic             sym_ready,
    input logic [SymW-1:0]  symbol,
    input logic             last_symbol
);

    logic [2:0] open_msgs_reg;
    logic       last_in;
    logic       last_out;

    assign last_in  = byte_valid && byte_ready && last_byte;
    assign last_out = sym_valid && sym_ready && last_symbol;

    // Messages whose final byte has been taken but whose final word has not left.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_msgs_reg <= '0;
        end
        else if (last_in && !last_out)
        begin
            open_msgs_reg <= open_msgs_reg + 3'd1;
        end
        else if (last_out && !last_in)
        begin
            open_msgs_reg <= open_msgs_reg - 3'd1;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> sym_valid)
        else $error("Output word withdrawn before it was taken.");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && !sym_ready |=> $stable(symbol) && $stable(last_symbol))
        else $error("Output word changed while stalled.");

    a_last_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |-> (open_msgs_reg != 3'd0) || last_in)
        else $error("Final word of a message without a final byte.");

    a_open_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_msgs_reg <= 3'd2)
        else $error("Too many messages awaiting their final word.");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !sym_valid)
        else $error("Output word valid straight after reset.");

endmodule

bind byte_to_5bit_symbol_splitter bsp_checker u_bsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .last_byte   (last_byte),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .symbol      (symbol),
    .last_symbol (last_symbol)
);

// ===== tb/tb_byte_to_5bit_symbol_splitter.sv =====
`timescale 1ns / 1ps

module tb_byte_to_5bit_symbol_splitter;
    import bsp_pkg::*;

    localparam int NumDirected = 15;
    localparam int NumRandom   = 160;
    localparam int StallLimit  = 1000;

    typedef struct packed {
        sym_t symbol;
        logic last;
    } sym_word_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
        logic [1:0]       n_typed;
        sym_t             s0;
        logic             l0;
        sym_t             s1;
        logic             l1;
        sym_t             s2;
        logic             l2;
    } dir_row_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             byte_valid  = 1'b0;
    logic             byte_ready;
    logic [ByteW-1:0] data_byte   = '0;
    logic             last_byte   = 1'b0;
    logic             sym_valid;
    logic             sym_ready   = 1'b0;
    sym_t             symbol;
    logic             last_symbol;

    logic [ResW-1:0]  res_bits  = '0;
    logic [CntW-1:0]  res_count = '0;
    sym_word_t        split_out [MaxSyms];
    sym_word_t        expected_syms [$];
    dir_row_t         dir_table [NumDirected];

    bit quiet       = 1'b0;
    int mismatches  = 0;
    int bytes_sent  = 0;
    int messages    = 0;
    int syms_seen   = 0;
    int idle_cycles = 0;

    byte_to_5bit_symbol_splitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .sym_valid   (sym_valid),
        .sym_ready   (sym_ready),
        .symbol      (symbol),
        .last_symbol (last_symbol)
    );

    always #10 clk = ~clk;

    function automatic int split_byte(input logic [ByteW-1:0] d, input logic l);
        int cnt;
        int acc;
        int n;
        int k;
        cnt = (res_count > ResMax) ? int'(ResMax) : int'(res_count);
        acc = ((int'(res_bits) & ((1 << cnt) - 1)) << ByteW) | int'(d);
        n = cnt + ByteW;
        k = 0;
        while (n >= SymW)
        begin
            split_out[k].symbol = sym_t'((acc >> (n - SymW)) & int'(SymMask));
            split_out[k].last   = 1'b0;
            k++;
            n -= SymW;
        end
        acc &= (1 << n) - 1;
        if (l)
        begin
            if (n > 0)
            begin
                split_out[k].symbol = sym_t'((acc << (SymW - n)) & int'(SymMask));
                split_out[k].last   = 1'b1;
                k++;
            end
            else
            begin
                split_out[k-1].last = 1'b1;
            end
            res_bits  = '0;
            res_count = '0;
        end
        else
        begin
            res_bits  = acc[ResW-1:0];
            res_count = CntW'(n);
        end
        return k;
    endfunction

    function automatic bit take_idle();
        return !quiet && ($urandom_range(0, 99) < 12);
    endfunction

    task automatic note_mismatch(input string what, input sym_word_t want,
                                 input sym_word_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("Mismatch (%s): expected symbol %h last %b, got symbol %h last %b",
                     what, want.symbol, want.last, got.symbol, got.last);
        end
    endtask

    task automatic send_byte(input logic [ByteW-1:0] d, input logic l);
        while (take_idle())
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= d;
        last_byte  <= l;
        do
            @(posedge clk);
        while (!byte_ready);
        bytes_sent++;
        if (l)
        begin
            messages++;
        end
    endtask

    task automatic send_predicted(input logic [ByteW-1:0] d, input logic l);
        int k;
        send_byte(d, l);
        k = split_byte(d, l);
        for (int i = 0; i < k; i++)
        begin
            expected_syms.push_back(split_out[i]);
        end
    endtask

    always @(posedge clk)
    begin : sym_sink
        sym_word_t want;
        sym_word_t got;
        sym_ready <= quiet || ($urandom_range(0, 99) >= 12);
        if (rst_n && sym_valid && sym_ready)
        begin
            got.symbol = symbol;
            got.last   = last_symbol;
            syms_seen++;
            if (expected_syms.size() == 0)
            begin
                note_mismatch("unexpected word", '0, got);
            end
            else
            begin
                want = expected_syms.pop_front();
                if (got.symbol !== want.symbol)
                begin
                    note_mismatch("symbol", want, got);
                end
                else if (got.last !== want.last)
                begin
                    note_mismatch("last_symbol", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (sym_valid && sym_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= StallLimit)
        begin
            $display("Timeout: no word moved for %0d cycles", StallLimit);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t  row;
        sym_word_t typed_w [MaxSyms];
        int        left;
        int        len;

        dir_table[0]  = '{8'hFF, 1'b1, 2'd2, 5'h1F, 1'b0, 5'h1C, 1'b1, 5'h00, 1'b0};
        dir_table[1]  = '{8'h00, 1'b1, 2'd2, 5'h00, 1'b0, 5'h00, 1'b1, 5'h00, 1'b0};
        dir_table[2]  = '{8'h80, 1'b1, 2'd2, 5'h10, 1'b0, 5'h00, 1'b1, 5'h00, 1'b0};
        dir_table[3]  = '{8'h01, 1'b1, 2'd2, 5'h00, 1'b0, 5'h04, 1'b1, 5'h00, 1'b0};
        dir_table[4]  = '{8'hA5, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[5]  = '{8'h5A, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[6]  = '{8'hFF, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[7]  = '{8'h00, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[8]  = '{8'hC3, 1'b1, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[9]  = '{8'hF0, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[10] = '{8'h0F, 1'b1, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[11] = '{8'h33, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[12] = '{8'hCC, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[13] = '{8'h81, 1'b0, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};
        dir_table[14] = '{8'h7E, 1'b1, 2'd0, 5'h00, 1'b0, 5'h00, 1'b0, 5'h00, 1'b0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NumDirected; r++)
        begin
            row = dir_table[r];
            if (row.n_typed == 0)
            begin
                send_predicted(row.data, row.last);
            end
            else
            begin
                send_byte(row.data, row.last);
                void'(split_byte(row.data, row.last));
                typed_w[0] = '{row.s0, row.l0};
                typed_w[1] = '{row.s1, row.l1};
                typed_w[2] = '{row.s2, row.l2};
                for (int i = 0; i < int'(row.n_typed); i++)
                begin
                    expected_syms.push_back(typed_w[i]);
                end
            end
        end

        // Random messages, mostly short, with a quiet stretch in the middle where
        // neither side holds back a word.
        left = NumRandom;
        while (left > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            if (len > left)
            begin
                len = left;
            end
            for (int i = 0; i < len; i++)
            begin
                quiet = (left <= 100) && (left > 60);
                send_predicted(ByteW'($urandom_range(0, 255)), i == len - 1);
                left--;
            end
        end
        quiet = 1'b0;
        byte_valid <= 1'b0;

        while (expected_syms.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d messages and checked %0d symbols.",
                 bytes_sent, messages, syms_seen);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
